// ===== rtl/core/two_queue_weighted_batch_loader_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the weighted batch loader
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TWO_QUEUE_WEIGHTED_BATCH_LOADER_TOP_MACROS_SVH
`define TWO_QUEUE_WEIGHTED_BATCH_LOADER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TQWB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqwb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TQWB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqwb: next-cycle check failed");

`endif

// ===== rtl/core/tqwb_pkg.sv =====
// ----------------------------------------------------------------------------
// tqwb_pkg
// Shared types and constants of the two-queue weighted batch loader.
// ----------------------------------------------------------------------------
package tqwb_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam int FUNC_W      = 2;
    localparam int LIMIT_W     = 6;
    localparam int RUN_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST  = LIMIT_W'(10);
    localparam logic [RUN_W-1:0]   PRIMARY_RUN_RST = RUN_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_RUN = CFG_IDX_W'(1);

    // Command queue between the front and back ends.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_PRI = 2'd0,
        FUNC_PUSH_SEC = 2'd1,
        FUNC_LOAD     = 2'd2,
        FUNC_RSVD     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CMD_PUSH_PRI,
        CMD_PUSH_SEC,
        CMD_LOAD,
        CMD_IDLE
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [VALUE_WIDTH-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic                   push_accepted;
        logic                   entry_valid;
        logic                   entry_class;
        logic [VALUE_WIDTH-1:0] entry_value;
        logic                   shortage;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        t_cmd                   cmd;
        logic [VALUE_WIDTH-1:0] value;
    } t_cmd_entry;

    typedef struct packed {
        logic                   valid;
        t_cmd                   cmd;
        logic [VALUE_WIDTH-1:0] value;
    } t_fb_cmd;

    typedef struct packed {
        logic push_accepted;
        logic entry_valid;
        logic entry_class;
        logic shortage;
        logic last;
    } t_out_ctl;

endpackage

// ===== rtl/core/tqwb_in_if.sv =====
// ----------------------------------------------------------------------------
// tqwb_in_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface tqwb_in_if import tqwb_pkg::*; ();

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/tqwb_out_if.sv =====
// ----------------------------------------------------------------------------
// tqwb_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tqwb_out_if import tqwb_pkg::*; ();

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/tqwb_front.sv =====
// ----------------------------------------------------------------------------
// tqwb_front
// Accepts request transactions, decodes the function code and buffers the
// decoded commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module tqwb_front import tqwb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tqwb_in_if.sink    i_in,
    input  logic       i_pop,
    output t_fb_cmd    o_cmd
);

    t_cmd_entry               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]       r_wr_ptr;
    logic [CMDQ_AW-1:0]       r_rd_ptr;
    logic [CMDQ_CW-1:0]       r_count;
    logic [CMDQ_AW-1:0]       n_wr_ptr;
    logic [CMDQ_AW-1:0]       n_rd_ptr;
    logic                     w_push;
    t_cmd_entry               w_entry;

    always_comb begin
        case (t_func'(i_in.data.func))
            FUNC_PUSH_PRI: w_entry.cmd = CMD_PUSH_PRI;
            FUNC_PUSH_SEC: w_entry.cmd = CMD_PUSH_SEC;
            FUNC_LOAD:     w_entry.cmd = CMD_LOAD;
            default:       w_entry.cmd = CMD_IDLE;
        endcase
        w_entry.value = i_in.data.item_value;
    end

    assign i_in.ready = (r_count != CMDQ_CW'(CMDQ_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;

    assign n_wr_ptr = (r_wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.cmd   = r_q[r_rd_ptr].cmd;
    assign o_cmd.value = r_q[r_rd_ptr].value;

endmodule

// ===== rtl/core/tqwb_back.sv =====
// ----------------------------------------------------------------------------
// tqwb_back
// Holds both ring queues and the configuration, executes pushes and steps
// through a load one entry per cycle into the result register while the output is not stalled.
// ----------------------------------------------------------------------------
module tqwb_back import tqwb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_fb_cmd               i_cmd,
    output logic                  o_pop,
    tqwb_out_if.source            o_out
);

    logic [VALUE_WIDTH-1:0] mem_p [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0] mem_s [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0] r_p_rd;
    logic [VALUE_WIDTH-1:0] r_s_rd;

    logic [LIMIT_W-1:0]     r_load_limit;
    logic [RUN_W-1:0]       r_primary_run;
    logic [Q_AW-1:0]        r_p_head;
    logic [Q_AW-1:0]        r_p_tail;
    logic [Q_CW-1:0]        r_p_count;
    logic [Q_AW-1:0]        r_s_head;
    logic [Q_AW-1:0]        r_s_tail;
    logic [Q_CW-1:0]        r_s_count;
    logic [RUN_W-1:0]       r_cnt;
    logic [LIMIT_W-1:0]     r_total;
    logic                   r_out_valid;
    t_out_ctl               r_out;

    t_out_ctl               n_out;
    logic [RUN_W-1:0]       n_cnt;
    logic [RUN_W-1:0]       w_run;
    logic                   w_go;
    logic                   w_p_ne;
    logic                   w_s_ne;
    logic                   w_p_full;
    logic                   w_s_full;
    logic                   w_lim_ok;
    logic                   w_under_run;
    logic                   w_pick_p;
    logic                   w_pick_s;
    logic                   w_pop_any;
    logic [LIMIT_W:0]       w_total_inc;
    logic [Q_CW-1:0]        w_p_left;
    logic [Q_CW-1:0]        w_s_left;
    logic                   w_load_last;
    logic                   w_load_short;
    logic                   w_step_last;
    logic                   w_wr_p;
    logic                   w_wr_s;
    logic                   w_rd_p;
    logic                   w_rd_s;

    // A run length of zero behaves as one.
    assign w_run       = (r_primary_run == '0) ? RUN_W'(1) : r_primary_run;
    assign w_go        = i_cmd.valid && (!r_out_valid || o_out.ready);
    assign w_p_ne      = (r_p_count != '0);
    assign w_s_ne      = (r_s_count != '0);
    assign w_p_full    = (r_p_count == Q_CW'(QUEUE_DEPTH));
    assign w_s_full    = (r_s_count == Q_CW'(QUEUE_DEPTH));
    assign w_lim_ok    = (r_load_limit != '0);
    assign w_under_run = (r_cnt < w_run);

    // Primary entries are taken while the run is open; once it is complete a
    // secondary entry is due. With no secondary entry waiting the run starts
    // over, and with the primary queue dry the secondary queue stands in.
    assign w_pick_p  = w_lim_ok && w_p_ne && (w_under_run || !w_s_ne);
    assign w_pick_s  = w_lim_ok && w_s_ne && (!w_p_ne || !w_under_run);
    assign w_pop_any = w_pick_p || w_pick_s;

    assign w_total_inc  = {1'b0, r_total} + 1'b1;
    assign w_p_left     = r_p_count - Q_CW'(w_pick_p);
    assign w_s_left     = r_s_count - Q_CW'(w_pick_s);
    assign w_load_last  = !w_pop_any || (w_total_inc == {1'b0, r_load_limit}) ||
                          ((w_p_left == '0) && (w_s_left == '0));
    assign w_load_short = w_pop_any ? (w_total_inc < {1'b0, r_load_limit}) : w_lim_ok;

    always_comb begin
        n_out       = '0;
        w_wr_p      = 1'b0;
        w_wr_s      = 1'b0;
        w_rd_p      = 1'b0;
        w_rd_s      = 1'b0;
        w_step_last = 1'b1;
        n_cnt       = r_cnt;
        case (i_cmd.cmd)
            CMD_PUSH_PRI: begin
                n_out.push_accepted = !w_p_full;
                n_out.last          = 1'b1;
                w_wr_p              = w_go && !w_p_full;
            end
            CMD_PUSH_SEC: begin
                n_out.push_accepted = !w_s_full;
                n_out.last          = 1'b1;
                w_wr_s              = w_go && !w_s_full;
            end
            CMD_LOAD: begin
                n_out.entry_valid = w_pop_any;
                n_out.entry_class = w_pick_s;
                n_out.shortage    = w_load_last && w_load_short;
                n_out.last        = w_load_last;
                w_rd_p            = w_go && w_pick_p;
                w_rd_s            = w_go && w_pick_s;
                w_step_last       = w_load_last;
                if (w_pick_p) begin
                    n_cnt = w_under_run ? r_cnt + 1'b1 : RUN_W'(1);
                end else begin
                    n_cnt = '0;
                end
            end
            default: begin
                n_out.last = 1'b1;
            end
        endcase
    end

    assign o_pop = w_go && w_step_last;

    always_ff @(posedge i_clk) begin
        if (w_wr_p) begin
            mem_p[r_p_tail] <= i_cmd.value;
        end
        if (w_rd_p) begin
            r_p_rd <= mem_p[r_p_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_s) begin
            mem_s[r_s_tail] <= i_cmd.value;
        end
        if (w_rd_s) begin
            r_s_rd <= mem_s[r_s_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit  <= LOAD_LIMIT_RST;
            r_primary_run <= PRIMARY_RUN_RST;
            r_p_head      <= '0;
            r_p_tail      <= '0;
            r_p_count     <= '0;
            r_s_head      <= '0;
            r_s_tail      <= '0;
            r_s_count     <= '0;
            r_cnt         <= '0;
            r_total       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LOAD_LIMIT:  r_load_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_PRIMARY_RUN: r_primary_run <= i_cfg_data[RUN_W-1:0];
                    default:         r_load_limit  <= r_load_limit;
                endcase
            end

            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_wr_p) begin
                r_p_tail  <= (r_p_tail == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_p_tail + 1'b1;
                r_p_count <= r_p_count + 1'b1;
            end
            if (w_wr_s) begin
                r_s_tail  <= (r_s_tail == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_s_tail + 1'b1;
                r_s_count <= r_s_count + 1'b1;
            end
            if (w_rd_p) begin
                r_p_head  <= (r_p_head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_p_head + 1'b1;
                r_p_count <= w_p_left;
            end
            if (w_rd_s) begin
                r_s_head  <= (r_s_head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_s_head + 1'b1;
                r_s_count <= w_s_left;
            end

            if (w_go && (i_cmd.cmd == CMD_LOAD)) begin
                if (w_load_last) begin
                    r_cnt   <= '0;
                    r_total <= '0;
                end else begin
                    r_cnt   <= n_cnt;
                    r_total <= w_total_inc[LIMIT_W-1:0];
                end
            end
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.data.push_accepted = r_out.push_accepted;
    assign o_out.data.entry_valid   = r_out.entry_valid;
    assign o_out.data.entry_class   = r_out.entry_class;
    assign o_out.data.entry_value   = !r_out.entry_valid ? '0 :
                                      (r_out.entry_class ? r_s_rd : r_p_rd);
    assign o_out.data.shortage      = r_out.shortage;
    assign o_out.data.last          = r_out.last;

endmodule

// ===== rtl/core/two_queue_weighted_batch_loader_top.sv =====
// ----------------------------------------------------------------------------
// two_queue_weighted_batch_loader_top
// Path: a request passes through the command queue and then the result register.
// Throughput: one result per cycle when not stalled; a load yields one per entry.
// Reset: synchronous, active low; empties both queues and restores the config.
// ----------------------------------------------------------------------------
`include "two_queue_weighted_batch_loader_top_macros.svh"

module two_queue_weighted_batch_loader_top import tqwb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tqwb_in_if.sink               i_in,
    tqwb_out_if.source            o_out
);

    t_fb_cmd w_cmd;
    logic    w_pop;

    tqwb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd)
    );

    tqwb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

    // The back end only retires a command that is actually queued.
    `TQWB_ASSERT_IMPL(a_pop_has_cmd, i_clk, i_rst_n, w_pop, w_cmd.valid)
    // A queued command stays at the head until it has been retired.
    `TQWB_ASSERT_NEXT(a_cmd_held, i_clk, i_rst_n, w_cmd.valid && !w_pop, w_cmd.valid)
    // Only loaded entries may be followed by further results of the same transaction.
    `TQWB_ASSERT_IMPL(a_mid_is_entry, i_clk, i_rst_n, o_out.valid && !o_out.data.last, o_out.data.entry_valid)
    // An accepted push gives a single result that carries no entry.
    `TQWB_ASSERT_IMPL(a_push_alone, i_clk, i_rst_n, o_out.valid && o_out.data.push_accepted, !o_out.data.entry_valid && o_out.data.last)

endmodule
